/* sv/slbd_pkg.sv */
// ----------------------------------------------------------------------------
// slbd_pkg: shared types, constants and calibration tables
// Breakpoint tables for the sensor and output stages, controller state and
// the command / status structs between controller and datapath.
// ----------------------------------------------------------------------------
package slbd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TEMP_W   = 10;
  localparam int CODE_W   = 8;
  localparam int BAR_W    = 8;
  localparam int IDX_W    = 4;
  localparam int QUO_W    = 16;

  localparam logic [IDX_W-1:0] SENSOR_LAST = IDX_W'(12 - 1);
  localparam logic [IDX_W-1:0] OUTPUT_LAST = IDX_W'(15 - 1);

  // bar graph thresholds in tenths
  localparam logic [15:0] BAR_LOW  = 16'd400;
  localparam logic [15:0] BAR_HIGH = 16'd800;
  localparam int          BAR_STEP = (800 - 400) / 8;

  // table select
  localparam logic PH_SENSOR = 1'b0;
  localparam logic PH_OUTPUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL,
    ST_DIVI,
    ST_DIV,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;         // capture a new sample
    logic step;         // advance to next breakpoint
    logic setup;        // latch segment deltas
    logic mul;          // product of offset and rise
    logic div_init;     // split product into sign and magnitude
    logic div_step;     // one quotient bit
    logic commit_y;     // result is the breakpoint output
    logic commit_base;  // result is the lower breakpoint output
    logic commit_q;     // result is base plus quotient
    logic out_load;     // move result into output register
  } cmd_t;

  typedef struct packed {
    logic le;           // value at or below current breakpoint
    logic first;        // at first breakpoint
    logic last;         // at last breakpoint
    logic di_zero;      // segment has zero width
    logic div_last;     // final quotient bit this cycle
    logic phase;        // current table
    logic out_busy;     // output register cannot take a beat
  } sts_t;

  function automatic logic [15:0] tab_x(input logic ph, input logic [IDX_W-1:0] idx);
    logic [15:0] x;
    x = 16'hFFFF;
    if (ph == PH_SENSOR) begin
      case (idx)
        4'd0:    x = 16'd24576;
        4'd1:    x = 16'd25166;
        4'd2:    x = 16'd25739;
        4'd3:    x = 16'd26293;
        4'd4:    x = 16'd26831;
        4'd5:    x = 16'd27353;
        4'd6:    x = 16'd27859;
        4'd7:    x = 16'd28351;
        4'd8:    x = 16'd28828;
        4'd9:    x = 16'd29293;
        4'd10:   x = 16'd29744;
        default: x = 16'd65535;
      endcase
    end else begin
      case (idx)
        4'd0:    x = 16'd0;
        4'd1:    x = 16'd100;
        4'd2:    x = 16'd180;
        4'd3:    x = 16'd220;
        4'd4:    x = 16'd290;
        4'd5:    x = 16'd420;
        4'd6:    x = 16'd480;
        4'd7:    x = 16'd520;
        4'd8:    x = 16'd570;
        4'd9:    x = 16'd640;
        4'd10:   x = 16'd700;
        4'd11:   x = 16'd760;
        4'd12:   x = 16'd810;
        4'd13:   x = 16'd1000;
        default: x = 16'd65535;
      endcase
    end
    return x;
  endfunction

  function automatic logic signed [15:0] tab_y(input logic ph,
                                               input logic [IDX_W-1:0] idx);
    logic signed [15:0] y;
    y = 16'sd0;
    if (ph == PH_SENSOR) begin
      case (idx)
        4'd0:    y = 16'sd0;
        4'd1:    y = 16'sd100;
        4'd2:    y = 16'sd200;
        4'd3:    y = 16'sd300;
        4'd4:    y = 16'sd400;
        4'd5:    y = 16'sd500;
        4'd6:    y = 16'sd600;
        4'd7:    y = 16'sd700;
        4'd8:    y = 16'sd800;
        4'd9:    y = 16'sd900;
        4'd10:   y = 16'sd1000;
        default: y = 16'sd1001;
      endcase
    end else begin
      case (idx)
        4'd0:    y = 16'sd255;
        4'd1:    y = 16'sd253;
        4'd2:    y = 16'sd228;
        4'd3:    y = 16'sd216;
        4'd4:    y = 16'sd195;
        4'd5:    y = 16'sd150;
        4'd6:    y = 16'sd131;
        4'd7:    y = 16'sd119;
        4'd8:    y = 16'sd105;
        4'd9:    y = 16'sd87;
        4'd10:   y = 16'sd74;
        4'd11:   y = 16'sd62;
        4'd12:   y = 16'sd53;
        4'd13:   y = 16'sd20;
        default: y = 16'sd15;
      endcase
    end
    return y;
  endfunction

endpackage

/* sv/slbd_in_if.sv */
// ----------------------------------------------------------------------------
// slbd_in_if: sample channel
// Valid/ready channel carrying one raw converter sample per beat.
// ----------------------------------------------------------------------------
interface slbd_in_if;
  import slbd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

/* sv/slbd_out_if.sv */
// ----------------------------------------------------------------------------
// slbd_out_if: result channel
// Valid/ready channel carrying temperature, output code and bar pattern.
// ----------------------------------------------------------------------------
interface slbd_out_if;
  import slbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temperature_tenths;
  logic [CODE_W-1:0] dac_code;
  logic [BAR_W-1:0]  led_bar;

  modport source (output valid, output temperature_tenths, output dac_code,
                  output led_bar, input ready);
  modport sink   (input valid, input temperature_tenths, input dac_code,
                  input led_bar, output ready);
endinterface

/* sv/slbd_ctrl.sv */
// ----------------------------------------------------------------------------
// slbd_ctrl: sequencing state machine
// Walks each table, runs multiply and serial divide for a segment hit, then
// hands the result to the output register. Issues commands to the datapath only.
// ----------------------------------------------------------------------------
module slbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  slbd_pkg::sts_t sts,
  output slbd_pkg::cmd_t cmd
);
  import slbd_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.le && sts.first) begin
          // at or below the first breakpoint
          cmd.commit_y = 1'b1;
          state_nxt    = (sts.phase == PH_SENSOR) ? ST_WALK : ST_DONE;
        end else if (sts.le) begin
          cmd.setup = 1'b1;
          state_nxt = ST_MUL;
        end else if (sts.last) begin
          // past the end of the table
          cmd.commit_y = 1'b1;
          state_nxt    = (sts.phase == PH_SENSOR) ? ST_WALK : ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_MUL: begin
        if (sts.di_zero) begin
          cmd.commit_base = 1'b1;
          state_nxt       = (sts.phase == PH_SENSOR) ? ST_WALK : ST_DONE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.commit_q = 1'b1;
        state_nxt    = (sts.phase == PH_SENSOR) ? ST_WALK : ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/slbd_dpath.sv */
// ----------------------------------------------------------------------------
// slbd_dpath: lookup and interpolation datapath
// Table index, segment deltas, one multiplier, a one-bit-per-cycle divider,
// the blink counter and the output register.
// ----------------------------------------------------------------------------
module slbd_dpath #(
  parameter int BLINK_SHIFT = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  slbd_pkg::cmd_t                  cmd,
  output slbd_pkg::sts_t                  sts,
  input  logic [slbd_pkg::SAMPLE_W-1:0]   in_sample,
  slbd_out_if.source                      out_ch
);
  import slbd_pkg::*;

  localparam int BLINK_W = BLINK_SHIFT + 1;

  logic                    phase_r;
  logic [IDX_W-1:0]        idx_r;
  logic [15:0]             v_r;
  logic [15:0]             dv_r;
  logic [15:0]             di_r;
  logic signed [16:0]      dout_r;
  logic signed [15:0]      base_r;
  logic signed [33:0]      prod_r;
  logic                    neg_r;
  logic [15:0]             rem_r;
  logic [QUO_W-1:0]        quo_r;
  logic [3:0]              cnt_r;
  logic [15:0]             temp_r;
  logic [CODE_W-1:0]       code_r;
  logic                    out_valid_r;
  logic [TEMP_W-1:0]       out_temp_r;
  logic [CODE_W-1:0]       out_code_r;
  logic [BAR_W-1:0]        out_bar_r;
  logic [BLINK_W-1:0]      blink_r;

  logic [15:0]             cur_x, prv_x;
  logic signed [15:0]      cur_y, prv_y;
  logic [IDX_W-1:0]        idx_last;
  logic [33:0]             mag;
  logic [16:0]             trial;
  logic                    ge;
  logic signed [16:0]      q_signed;
  logic signed [16:0]      sum;
  logic [15:0]             res;
  logic [BAR_W-1:0]        bar;

  // current and previous breakpoint
  assign cur_x    = tab_x(phase_r, idx_r);
  assign cur_y    = tab_y(phase_r, idx_r);
  assign prv_x    = tab_x(phase_r, idx_r - IDX_W'(1));
  assign prv_y    = tab_y(phase_r, idx_r - IDX_W'(1));
  assign idx_last = (phase_r == PH_SENSOR) ? SENSOR_LAST : OUTPUT_LAST;

  // divider step: restoring, one quotient bit a cycle
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign ge    = (trial >= {1'b0, di_r});
  assign mag   = prod_r[33] ? 34'(-prod_r) : 34'(prod_r);

  // interpolated sum, truncation toward zero comes from sign-magnitude divide
  assign q_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign sum      = $signed({base_r[15], base_r}) + q_signed;

  // commit value
  always_comb begin
    res = sum[15:0];
    if (cmd.commit_y) begin
      res = cur_y;
    end else if (cmd.commit_base) begin
      res = base_r;
    end
  end

  // bar pattern: LED k lit at or above 400 + 50*k; top LED blinks at 800 up
  always_comb begin
    for (int k = 0; k < BAR_W - 1; k++) begin
      bar[k] = (temp_r >= (BAR_LOW + 16'(BAR_STEP * k)));
    end
    bar[BAR_W-1] = (temp_r >= (BAR_LOW + 16'(BAR_STEP * (BAR_W - 1)))) &&
                   ((temp_r < BAR_HIGH) || blink_r[BLINK_SHIFT]);
  end

  // status to controller
  always_comb begin
    sts.le       = (v_r <= cur_x);
    sts.first    = (idx_r == '0);
    sts.last     = (idx_r == idx_last);
    sts.di_zero  = (di_r == '0);
    sts.div_last = (cnt_r == 4'hF);
    sts.phase    = phase_r;
    sts.out_busy = out_valid_r && !out_ch.ready;
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SENSOR;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      blink_r     <= '0;
    end else begin
      if (cmd.load) begin
        phase_r <= PH_SENSOR;
        idx_r   <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + IDX_W'(1);
      end else if ((cmd.commit_y || cmd.commit_base || cmd.commit_q) &&
                   phase_r == PH_SENSOR) begin
        phase_r <= PH_OUTPUT;
        idx_r   <= '0;
      end
      if (cmd.div_init) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 4'd1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        blink_r     <= blink_r + BLINK_W'(1);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r <= in_sample;
    end
    if (cmd.setup) begin
      dv_r   <= v_r - prv_x;
      di_r   <= cur_x - prv_x;
      dout_r <= $signed({cur_y[15], cur_y}) - $signed({prv_y[15], prv_y});
      base_r <= prv_y;
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, dv_r}) * dout_r;
    end
    if (cmd.div_init) begin
      neg_r <= prod_r[33];
      rem_r <= mag[31:16];
      quo_r <= mag[15:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? 16'(trial - {1'b0, di_r}) : trial[15:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
    if (cmd.commit_y || cmd.commit_base || cmd.commit_q) begin
      if (phase_r == PH_SENSOR) begin
        temp_r <= res;
        v_r    <= res;
      end else begin
        code_r <= res[CODE_W-1:0];
      end
    end
    if (cmd.out_load) begin
      out_temp_r <= temp_r[TEMP_W-1:0];
      out_code_r <= code_r;
      out_bar_r  <= bar;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.temperature_tenths = out_temp_r;
  assign out_ch.dac_code           = out_code_r;
  assign out_ch.led_bar            = out_bar_r;

endmodule

/* sv/sensor_linearize_bar_and_dac.sv */
// ----------------------------------------------------------------------------
// sensor_linearize_bar_and_dac: sensor linearizer with DAC code and LED bar
// Converts raw converter samples to tenths of a degree, an 8-bit output code
// and an 8-LED bar pattern.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per raw 16-bit converter sample (valid/ready).
//   out_ch : one beat per sample with temperature_tenths, dac_code, led_bar.
//   Each sample walks the sensor table one breakpoint a cycle; where it falls
//   inside a segment of nonzero width it then does one multiply and a serial
//   divide of 16 quotient bits. The temperature repeats this on the output
//   table. One sample is in flight at a time: the next sample is not accepted
//   until the current result has been moved into the output register.
//   in_ch.ready is high only while no sample is being processed. A finished
//   result sits in the output register; if out_ch is stalled the next sample
//   may still be accepted and processed, and it waits until the output
//   register frees.
//   Reset clears the sequencer, the output valid and the blink counter;
//   the top LED blinks at a period of 2^(BLINK_SHIFT+1) results from 80.0 up.
// ----------------------------------------------------------------------------
module sensor_linearize_bar_and_dac #(
  parameter int BLINK_SHIFT = 4
) (
  input logic        clk,
  input logic        rst_n,
  slbd_in_if.sink    in_ch,
  slbd_out_if.source out_ch
);
  import slbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  slbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  slbd_dpath #(
    .BLINK_SHIFT (BLINK_SHIFT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_sample (in_ch.adc_sample),
    .out_ch    (out_ch)
  );

endmodule
